[src/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define FIJS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checked at every clock edge, reset included.
`define FIJS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[src/fijs_pkg.sv]
// Types, constants and widths for the frame interval jitter statistics block.
package fijs_pkg;

    localparam int MAX_WINDOW    = 128;
    localparam int INTERVAL_BITS = 24;

    localparam int TS_W      = 48;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 8;
    localparam int MEAN_W    = 24;
    localparam int RES_W     = 32;
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W    = $clog2(2 * MAX_WINDOW);
    localparam int TOTAL_W   = INTERVAL_BITS + CNT_W;
    localparam int SQ_W      = 2 * TOTAL_W;
    localparam int S_W       = SQ_W + CNT_W;
    localparam int DIV_W     = S_W + 32;
    localparam int ROOT_IN_W = 64;
    localparam int FPS_K_W   = 20;
    localparam int JOBQ_DEPTH = 2;

    localparam logic [CFG_W-1:0]   WINDOW_LEN_RESET = 8'd128;
    localparam logic [FPS_K_W-1:0] FPS_K            = 20'd1000000;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_CYCLE = 2'd2,
        OP_NONE  = 2'd3
    } fijs_op_t;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] n;
    } fijs_job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SUM,
        BK_DEV,
        BK_MEAN_GO,
        BK_MEAN_WT,
        BK_FPS_GO,
        BK_FPS_WT,
        BK_SD_GO,
        BK_SD_WT,
        BK_SDQ_GO,
        BK_SDQ_WT,
        BK_REL_GO,
        BK_REL_WT,
        BK_RLQ_GO,
        BK_RLQ_WT,
        BK_OUT
    } fijs_state_t;

endpackage

[src/fijs_ram.sv]
// Generic simple dual-port RAM with registered read.
module fijs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[src/fijs_front.sv]
// Mark decoder: measures intervals, fills the interval store and posts window jobs.
module fijs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fijs_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fijs_pkg::OP_W-1:0]     s_op,
    input  logic [fijs_pkg::TS_W-1:0]     s_ts,
    input  logic                          pending,
    output logic                          wr_en,
    output logic [fijs_pkg::ADDR_W-1:0]   wr_addr,
    output logic [fijs_pkg::INTERVAL_BITS-1:0] wr_data,
    output logic                          job_push,
    output fijs_pkg::fijs_job_t           job
);
    logic [fijs_pkg::CFG_W-1:0] window_len_reg;
    logic [fijs_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       bank_reg, bank_next;
    logic [fijs_pkg::TS_W-1:0]  start_time_reg;
    logic                       start_valid_reg, start_valid_next;

    logic [fijs_pkg::CNT_W-1:0] n_eff;
    logic [fijs_pkg::CNT_W-1:0] count_inc;
    logic [fijs_pkg::TS_W-1:0]  diff;
    logic                       acc, active, is_end, is_start, store, done;

    always_comb begin
        if (32'(window_len_reg) > 32'(fijs_pkg::MAX_WINDOW)) begin
            n_eff = fijs_pkg::CNT_W'(fijs_pkg::MAX_WINDOW);
        end else begin
            n_eff = fijs_pkg::CNT_W'(window_len_reg);
        end

        // With a job pending, hold off all marks when the next interval would end a window.
        s_ready = !(pending && (32'(count_reg) + 32'd1 >= 32'(n_eff)));
        acc     = s_valid && s_ready;

        is_end   = 1'b0;
        is_start = 1'b0;
        unique case (fijs_pkg::fijs_op_t'(s_op))
            fijs_pkg::OP_START: is_start = 1'b1;
            fijs_pkg::OP_END:   is_end   = 1'b1;
            fijs_pkg::OP_CYCLE: begin
                is_end   = 1'b1;
                is_start = 1'b1;
            end
            default: ;
        endcase
        active = acc && (n_eff != '0);

        diff = s_ts - start_time_reg;
        if (diff > fijs_pkg::TS_W'({fijs_pkg::INTERVAL_BITS{1'b1}})) begin
            wr_data = '1;
        end else begin
            wr_data = diff[fijs_pkg::INTERVAL_BITS-1:0];
        end

        store     = active && is_end && start_valid_reg && (count_reg < n_eff);
        count_inc = count_reg + 1'b1;
        done      = store && (count_inc == n_eff);

        wr_en = store;
        if (bank_reg) begin
            wr_addr = fijs_pkg::ADDR_W'(fijs_pkg::MAX_WINDOW) + fijs_pkg::ADDR_W'(count_reg);
        end else begin
            wr_addr = fijs_pkg::ADDR_W'(count_reg);
        end

        job_push = done;
        job.bank = bank_reg;
        job.n    = n_eff;

        count_next = count_reg;
        bank_next  = bank_reg;
        if (store) begin
            count_next = done ? '0 : count_inc;
            bank_next  = done ? !bank_reg : bank_reg;
        end

        start_valid_next = start_valid_reg;
        if (active && is_end) begin
            start_valid_next = 1'b0;
        end
        if (active && is_start) begin
            start_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg  <= fijs_pkg::WINDOW_LEN_RESET;
            count_reg       <= '0;
            bank_reg        <= 1'b0;
            start_time_reg  <= '0;
            start_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_len_reg <= cfg_wdata;
                count_reg      <= '0;
            end else begin
                count_reg <= count_next;
            end
            bank_reg        <= bank_next;
            start_valid_reg <= start_valid_next;
            if (active && is_start) begin
                start_time_reg <= s_ts;
            end
        end
    end
endmodule

[src/fijs_jobq.sv]
// Short job queue between the mark decoder and the statistics engine.
`include "assert_macros.svh"
module fijs_jobq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fijs_pkg::fijs_job_t din,
    input  logic                pop,
    output fijs_pkg::fijs_job_t dout,
    output logic                empty
);
    localparam int PTR_W = $clog2(fijs_pkg::JOBQ_DEPTH);

    fijs_pkg::fijs_job_t                 entry_reg [fijs_pkg::JOBQ_DEPTH];
    logic [PTR_W-1:0]                    wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(fijs_pkg::JOBQ_DEPTH+1)-1:0] fill_reg;
    logic                                full;

    assign empty = (fill_reg == '0);
    assign full  = (32'(fill_reg) == fijs_pkg::JOBQ_DEPTH);
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    `FIJS_ASSERT(a_no_overflow, aclk, aresetn, push |-> !full)
    `FIJS_ASSERT(a_no_underflow, aclk, aresetn, pop |-> !empty)
endmodule

[src/fijs_div.sv]
// Restoring divider, one quotient bit per cycle.
module fijs_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fijs_pkg::DIV_W-1:0] num,
    input  logic [fijs_pkg::DIV_W-1:0] den,
    output logic                       busy,
    output logic                       done,
    output logic [fijs_pkg::DIV_W-1:0] quo
);
    localparam int CW = $clog2(fijs_pkg::DIV_W + 1);

    logic [fijs_pkg::DIV_W-1:0] qn_reg, den_reg, rem_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg, done_reg;
    logic [fijs_pkg::DIV_W:0]   trial;
    logic                       take;

    always_comb begin
        trial = {rem_reg, qn_reg[fijs_pkg::DIV_W-1]};
        take  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qn_reg  <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            qn_reg <= {qn_reg[fijs_pkg::DIV_W-2:0], take};
            if (take) begin
                rem_reg <= fijs_pkg::DIV_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[fijs_pkg::DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(fijs_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = qn_reg;
endmodule

[src/fijs_sqrt.sv]
// Integer square root of a 64-bit value, two radicand bits per cycle.
module fijs_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [fijs_pkg::ROOT_IN_W-1:0] v,
    output logic                           done,
    output logic [fijs_pkg::RES_W-1:0]     root
);
    localparam int W = fijs_pkg::ROOT_IN_W;

    logic [W-1:0] rem_reg, res_reg, sbit_reg;
    logic         busy_reg, done_reg;
    logic [W-1:0] cand;

    assign cand = res_reg + sbit_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= v;
            res_reg  <= '0;
            sbit_reg <= W'(1) << (W - 2);
        end else if (busy_reg) begin
            if (rem_reg >= cand) begin
                rem_reg <= rem_reg - cand;
                res_reg <= (res_reg >> 1) + sbit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && sbit_reg == W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[fijs_pkg::RES_W-1:0];
endmodule

[src/fijs_back.sv]
// Statistics engine: two passes over a window, then the divisions and roots.
`include "assert_macros.svh"
module fijs_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  fijs_pkg::fijs_job_t                 q_job,
    output logic                                q_pop,
    output logic                                busy,
    output logic                                rd_en,
    output logic [fijs_pkg::ADDR_W-1:0]         rd_addr,
    input  logic [fijs_pkg::INTERVAL_BITS-1:0]  rd_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [119:0]                        m_data
);
    localparam int NN_W  = 2 * fijs_pkg::CNT_W;
    localparam int DSD_W = 3 * fijs_pkg::CNT_W;
    localparam int DRL_W = fijs_pkg::SQ_W + fijs_pkg::CNT_W;
    localparam int FN_W  = fijs_pkg::CNT_W + fijs_pkg::FPS_K_W;

    fijs_pkg::fijs_state_t state_reg, state_next;
    fijs_pkg::fijs_job_t   job_reg;
    logic [fijs_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                         rdv_reg, v1_reg, v2_reg, v3_reg;
    logic [fijs_pkg::TOTAL_W-1:0] nx_reg, dev_reg, total_reg;
    logic [fijs_pkg::SQ_W-1:0]    sq_reg;
    logic [fijs_pkg::S_W-1:0]     s_reg;
    logic [NN_W-1:0]              nn_reg;
    logic [DSD_W-1:0]             den_sd_reg;
    logic [fijs_pkg::SQ_W-1:0]    tt_reg;
    logic [DRL_W-1:0]             den_rel_reg;
    logic [FN_W-1:0]              fps_num_reg;
    logic [fijs_pkg::MEAN_W-1:0]  mean_reg, mean_next;
    logic [fijs_pkg::RES_W-1:0]   sd_reg, sd_next, fps_reg, fps_next, rel_reg, rel_next;
    logic                         m_valid_reg, m_valid_next;
    logic [119:0]                 m_data_reg;

    logic                         div_go, div_busy, div_done;
    logic [fijs_pkg::DIV_W-1:0]   div_num, div_den, div_quo;
    logic                         sq_go, sq_done;
    logic [fijs_pkg::RES_W-1:0]   sq_root;
    logic                         quo_hi, n_ge2, tot_nz, load_out, in_pass, pass_end;
    logic [fijs_pkg::CNT_W-1:0]   n;

    fijs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go), .num(div_num), .den(div_den),
        .busy(div_busy), .done(div_done), .quo(div_quo)
    );

    fijs_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_go),
        .v(div_quo[fijs_pkg::ROOT_IN_W-1:0]), .done(sq_done), .root(sq_root)
    );

    always_comb begin
        n      = job_reg.n;
        n_ge2  = (n >= fijs_pkg::CNT_W'(2));
        tot_nz = (total_reg != '0);
        quo_hi = |div_quo[fijs_pkg::DIV_W-1:fijs_pkg::ROOT_IN_W];

        in_pass = (state_reg == fijs_pkg::BK_SUM) || (state_reg == fijs_pkg::BK_DEV);
        rd_en   = in_pass && (idx_reg < n);
        if (job_reg.bank) begin
            rd_addr = fijs_pkg::ADDR_W'(fijs_pkg::MAX_WINDOW) + fijs_pkg::ADDR_W'(idx_reg);
        end else begin
            rd_addr = fijs_pkg::ADDR_W'(idx_reg);
        end
        pass_end = (idx_reg == n) && !rdv_reg && !v1_reg && !v2_reg && !v3_reg;

        div_go  = 1'b0;
        div_num = '0;
        div_den = '0;
        sq_go   = 1'b0;
        q_pop   = 1'b0;
        load_out = 1'b0;

        state_next = state_reg;
        idx_next   = rd_en ? idx_reg + 1'b1 : idx_reg;
        mean_next  = mean_reg;
        sd_next    = sd_reg;
        fps_next   = fps_reg;
        rel_next   = rel_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            fijs_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    idx_next   = '0;
                    state_next = fijs_pkg::BK_SUM;
                end
            end
            fijs_pkg::BK_SUM: begin
                if (pass_end) begin
                    idx_next   = '0;
                    state_next = fijs_pkg::BK_DEV;
                end
            end
            fijs_pkg::BK_DEV: begin
                if (pass_end) begin
                    state_next = fijs_pkg::BK_MEAN_GO;
                end
            end
            fijs_pkg::BK_MEAN_GO: begin
                div_go     = 1'b1;
                div_num    = fijs_pkg::DIV_W'(total_reg);
                div_den    = fijs_pkg::DIV_W'(n);
                state_next = fijs_pkg::BK_MEAN_WT;
            end
            fijs_pkg::BK_MEAN_WT: begin
                if (div_done) begin
                    if (div_quo > fijs_pkg::DIV_W'({fijs_pkg::MEAN_W{1'b1}})) begin
                        mean_next = '1;
                    end else begin
                        mean_next = div_quo[fijs_pkg::MEAN_W-1:0];
                    end
                    if (tot_nz) begin
                        state_next = fijs_pkg::BK_FPS_GO;
                    end else if (n_ge2) begin
                        state_next = fijs_pkg::BK_SD_GO;
                    end else begin
                        sd_next    = '0;
                        state_next = fijs_pkg::BK_OUT;
                    end
                end
            end
            fijs_pkg::BK_FPS_GO: begin
                div_go     = 1'b1;
                div_num    = fijs_pkg::DIV_W'({fps_num_reg, 16'd0});
                div_den    = fijs_pkg::DIV_W'(total_reg);
                state_next = fijs_pkg::BK_FPS_WT;
            end
            fijs_pkg::BK_FPS_WT: begin
                if (div_done) begin
                    if (|div_quo[fijs_pkg::DIV_W-1:fijs_pkg::RES_W]) begin
                        fps_next = '1;
                    end else begin
                        fps_next = div_quo[fijs_pkg::RES_W-1:0];
                    end
                    if (n_ge2) begin
                        state_next = fijs_pkg::BK_SD_GO;
                    end else begin
                        sd_next    = '0;
                        rel_next   = '0;
                        state_next = fijs_pkg::BK_OUT;
                    end
                end
            end
            fijs_pkg::BK_SD_GO: begin
                div_go     = 1'b1;
                div_num    = fijs_pkg::DIV_W'({s_reg, 16'd0});
                div_den    = fijs_pkg::DIV_W'(den_sd_reg);
                state_next = fijs_pkg::BK_SD_WT;
            end
            fijs_pkg::BK_SD_WT: begin
                if (div_done) begin
                    if (quo_hi) begin
                        sd_next    = '1;
                        state_next = tot_nz ? fijs_pkg::BK_REL_GO : fijs_pkg::BK_OUT;
                    end else begin
                        state_next = fijs_pkg::BK_SDQ_GO;
                    end
                end
            end
            fijs_pkg::BK_SDQ_GO: begin
                sq_go      = 1'b1;
                state_next = fijs_pkg::BK_SDQ_WT;
            end
            fijs_pkg::BK_SDQ_WT: begin
                if (sq_done) begin
                    sd_next    = sq_root;
                    state_next = tot_nz ? fijs_pkg::BK_REL_GO : fijs_pkg::BK_OUT;
                end
            end
            fijs_pkg::BK_REL_GO: begin
                div_go     = 1'b1;
                div_num    = fijs_pkg::DIV_W'({s_reg, 32'd0});
                div_den    = fijs_pkg::DIV_W'(den_rel_reg);
                state_next = fijs_pkg::BK_REL_WT;
            end
            fijs_pkg::BK_REL_WT: begin
                if (div_done) begin
                    if (quo_hi) begin
                        rel_next   = '1;
                        state_next = fijs_pkg::BK_OUT;
                    end else begin
                        state_next = fijs_pkg::BK_RLQ_GO;
                    end
                end
            end
            fijs_pkg::BK_RLQ_GO: begin
                sq_go      = 1'b1;
                state_next = fijs_pkg::BK_RLQ_WT;
            end
            fijs_pkg::BK_RLQ_WT: begin
                if (sq_done) begin
                    rel_next   = sq_root;
                    state_next = fijs_pkg::BK_OUT;
                end
            end
            fijs_pkg::BK_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = fijs_pkg::BK_IDLE;
                end
            end
            default: state_next = fijs_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fijs_pkg::BK_IDLE;
            idx_reg     <= '0;
            rdv_reg     <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            fps_reg     <= '0;
            rel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rdv_reg     <= rd_en;
            v1_reg      <= rdv_reg && (state_reg == fijs_pkg::BK_DEV);
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            fps_reg     <= fps_next;
            rel_reg     <= rel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers; the denominators settle during the deviation pass.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg   <= q_job;
            total_reg <= '0;
            s_reg     <= '0;
        end else begin
            if (rdv_reg && state_reg == fijs_pkg::BK_SUM) begin
                total_reg <= total_reg + fijs_pkg::TOTAL_W'(rd_data);
            end
            if (v3_reg) begin
                s_reg <= s_reg + fijs_pkg::S_W'(sq_reg);
            end
        end
        nx_reg <= fijs_pkg::TOTAL_W'(n * rd_data);
        if (nx_reg >= total_reg) begin
            dev_reg <= nx_reg - total_reg;
        end else begin
            dev_reg <= total_reg - nx_reg;
        end
        sq_reg      <= fijs_pkg::SQ_W'(dev_reg * dev_reg);
        nn_reg      <= NN_W'(n * n);
        den_sd_reg  <= DSD_W'(nn_reg * (n - 1'b1));
        tt_reg      <= fijs_pkg::SQ_W'(total_reg * total_reg);
        den_rel_reg <= DRL_W'(tt_reg * (n - 1'b1));
        fps_num_reg <= FN_W'(n * fijs_pkg::FPS_K);
        mean_reg    <= mean_next;
        sd_reg      <= sd_next;
        if (load_out) begin
            m_data_reg <= {rel_next, fps_next, sd_next, mean_next};
        end
    end

    assign busy    = (state_reg != fijs_pkg::BK_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FIJS_ASSERT(a_div_start_idle, aclk, aresetn, div_go |-> !div_busy)
    `FIJS_ASSERT(a_load_slot_free, aclk, aresetn, load_out |-> (!m_valid_reg || m_ready))
endmodule

[src/frame_interval_jitter_stats.sv]
// Frame interval jitter statistics. Marks come as beats (start, end or cycle, with a
// microsecond timestamp); an end or cycle mark after a start writes the saturated interval
// into one half of a double-buffered interval store. When the window fills, a job goes to
// the statistics engine and the decoder carries on into the other half; once the next
// interval would close a window while a job is still queued or in the engine, the decoder
// holds off every mark. The engine makes two passes over the store, then up to four
// divisions in one shared bit-serial divider and up to two roots. Results are registered,
// so a single waiting result does not block new marks; once the next result is ready
// too, the engine stalls and marks are held off. There is no clearing pass after reset.
module frame_interval_jitter_stats (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,      // window_len
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // [47:0] timestamp_us
    input  logic [1:0]   s_axis_tuser,   // [1:0] op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] mean_us, [55:24] std_dev_q8, [87:56] fps_q16, [119:88] rel_sd_q16
    output logic [119:0] m_axis_tdata
);
    logic                                wr_en, rd_en, job_push, q_pop, q_empty, bk_busy;
    logic [fijs_pkg::ADDR_W-1:0]         wr_addr, rd_addr;
    logic [fijs_pkg::INTERVAL_BITS-1:0]  wr_data, rd_data;
    fijs_pkg::fijs_job_t                 job_in, job_out;

    fijs_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_op(s_axis_tuser),
        .s_ts(s_axis_tdata), .pending(!q_empty || bk_busy),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_push(job_push), .job(job_in)
    );

    fijs_ram #(
        .WIDTH(fijs_pkg::INTERVAL_BITS),
        .DEPTH(2 * fijs_pkg::MAX_WINDOW)
    ) u_store (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
        .re(rd_en), .raddr(rd_addr), .rdata(rd_data)
    );

    fijs_jobq u_jobq (
        .aclk(aclk), .aresetn(aresetn), .push(job_push), .din(job_in),
        .pop(q_pop), .dout(job_out), .empty(q_empty)
    );

    fijs_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_empty(q_empty), .q_job(job_out),
        .q_pop(q_pop), .busy(bk_busy), .rd_en(rd_en), .rd_addr(rd_addr),
        .rd_data(rd_data), .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_data(m_axis_tdata)
    );
endmodule

[tb/sv/frame_interval_jitter_stats_test.sv]
// Self-checking testbench for the frame interval jitter statistics block.
`timescale 1ns / 1ps

class jitter_scoreboard;
    bit [fijs_pkg::INTERVAL_BITS-1:0] intervals [fijs_pkg::MAX_WINDOW];
    int unsigned                      fill;
    bit [fijs_pkg::TS_W-1:0]          start_ts;
    bit                               start_seen;
    bit [fijs_pkg::RES_W-1:0]         prev_fps;
    bit [fijs_pkg::RES_W-1:0]         prev_rel;
    bit [fijs_pkg::CFG_W-1:0]         win_len;
    bit [119:0]                       stats_due [$];
    int                               errors;

    function void clear();
        fill = 0;
        start_ts = '0;
        start_seen = 0;
        prev_fps = '0;
        prev_rel = '0;
        win_len = fijs_pkg::WINDOW_LEN_RESET;
        stats_due.delete();
        errors = 0;
    endfunction

    function void set_window(bit [fijs_pkg::CFG_W-1:0] v);
        win_len = v;
        fill = 0;
    endfunction

    function int unsigned span();
        return (win_len > fijs_pkg::MAX_WINDOW) ? fijs_pkg::MAX_WINDOW : win_len;
    endfunction

    // Integer square root, saturated to 32 bits when the operand exceeds 64 bits.
    function bit [31:0] root_floor(bit [127:0] q);
        bit [63:0] v, res, b;
        if (q[127:64] != 0) return '1;
        v = q[63:0];
        res = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res[31:0];
    endfunction

    function void close_interval(bit [fijs_pkg::TS_W-1:0] ts);
        bit [63:0]  n, total, d, nx, dev, mean, f, sat;
        bit [127:0] s;
        bit [31:0]  sd;
        n = 64'(span());
        sat = 64'({fijs_pkg::INTERVAL_BITS{1'b1}});
        if (start_seen && fill < n) begin
            d = {16'h0, ts - start_ts};
            if (d > sat) d = sat;
            intervals[fill] = d[fijs_pkg::INTERVAL_BITS-1:0];
            fill++;
        end
        start_seen = 0;
        if (fill < n) return;
        total = 0;
        s = 0;
        for (int i = 0; i < n; i++) total += 64'(intervals[i]);
        for (int i = 0; i < n; i++) begin
            nx = n * 64'(intervals[i]);
            dev = (nx >= total) ? nx - total : total - nx;
            s += 128'(dev) * 128'(dev);
        end
        mean = total / n;
        if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
        sd = 0;
        if (n >= 2) sd = root_floor((s << 16) / 128'(n * n * (n - 1)));
        if (total > 0) begin
            f = (n * 64'd1000000 * 64'd65536) / total;
            prev_fps = (f > 64'hFFFFFFFF) ? '1 : f[31:0];
            if (n >= 2)
                prev_rel = root_floor((s << 32) / (128'(total * (n - 1)) * 128'(total)));
            else
                prev_rel = 0;
        end
        stats_due.push_back({prev_rel, prev_fps, sd, mean[fijs_pkg::MEAN_W-1:0]});
        fill = 0;
    endfunction

    function void note_mark(fijs_pkg::fijs_op_t op, bit [fijs_pkg::TS_W-1:0] ts);
        if (span() == 0 || op == fijs_pkg::OP_NONE) return;
        if (op == fijs_pkg::OP_END || op == fijs_pkg::OP_CYCLE) close_interval(ts);
        if (op == fijs_pkg::OP_START || op == fijs_pkg::OP_CYCLE) begin
            start_ts = ts;
            start_seen = 1;
        end
    endfunction

    function void check_result(bit [119:0] got);
        bit [119:0] want;
        if (stats_due.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
        end
        want = stats_due.pop_front();
        if (got[23:0] != want[23:0]) begin
            $error("mean_us: expected %0d, got %0d", want[23:0], got[23:0]);
            errors++;
        end
        if (got[55:24] != want[55:24]) begin
            $error("std_dev_q8: expected %0d, got %0d", want[55:24], got[55:24]);
            errors++;
        end
        if (got[87:56] != want[87:56]) begin
            $error("fps_q16: expected %0d, got %0d", want[87:56], got[87:56]);
            errors++;
        end
        if (got[119:88] != want[119:88]) begin
            $error("rel_sd_q16: expected %0d, got %0d", want[119:88], got[119:88]);
            errors++;
        end
    endfunction
endclass

module frame_interval_jitter_stats_test;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 1000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [7:0]   cfg_wdata = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;   // [47:0] timestamp_us
    logic [1:0]   s_axis_tuser = '0;   // [1:0] op
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    // [23:0] mean_us, [55:24] std_dev_q8, [87:56] fps_q16, [119:88] rel_sd_q16
    logic [119:0] m_axis_tdata;

    jitter_scoreboard sb = new();
    int                      send_idle = 0;
    int                      recv_stall = 0;
    int                      hold_left = 0;
    int                      quiet_cycles = 0;
    bit [fijs_pkg::TS_W-1:0] now_us;

    frame_interval_jitter_stats uut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_mark(fijs_pkg::fijs_op_t op, bit [fijs_pkg::TS_W-1:0] ts);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= ts;
        s_axis_tuser <= op;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_mark(op, ts);
    endtask

    // Lets outstanding windows drain, then waits out any engine work still in flight.
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.stats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_window(bit [fijs_pkg::CFG_W-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_window(v);
    endtask

    task automatic set_idling(int mode);
        @(negedge aclk);
        case (mode % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 87; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 87; end
            default: begin send_idle = 8; recv_stall = 8; end
        endcase
    endtask

    function automatic bit [fijs_pkg::TS_W-1:0] frame_gap();
        case ($urandom_range(19))
            0: return '0;
            1: return fijs_pkg::TS_W'($urandom_range(1, 3));
            2: return fijs_pkg::TS_W'(48'hFFFFFF + 48'($urandom_range(0, 5)));
            3: return fijs_pkg::TS_W'({$urandom, $urandom});
            default: return fijs_pkg::TS_W'($urandom_range(500, 50000));
        endcase
    endfunction

    task automatic run_marks(int count);
        int sent;
        int r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 70) begin
                now_us += frame_gap();
                send_mark(fijs_pkg::OP_CYCLE, now_us);
                sent++;
            end else if (r < 85) begin
                now_us += frame_gap();
                send_mark(fijs_pkg::OP_START, now_us);
                now_us += frame_gap();
                send_mark(fijs_pkg::OP_END, now_us);
                sent += 2;
            end else begin
                send_mark(fijs_pkg::fijs_op_t'($urandom_range(3)),
                          fijs_pkg::TS_W'({$urandom, $urandom}));
                sent++;
            end
        end
    endtask

    initial begin
        int lens [9] = '{3, 2, 5, 1, 128, 0, 255, 4, 7};
        int cnts [9] = '{30, 30, 30, 15, 180, 10, 25, 20, 20};
        sb.clear();
        now_us = fijs_pkg::TS_W'({$urandom, $urandom});
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: windows of one, two and zero, wrapped and saturated intervals, zero totals, noise.
        write_window(1);
        send_mark(fijs_pkg::OP_START, 48'h0);
        send_mark(fijs_pkg::OP_END, 48'h5);
        send_mark(fijs_pkg::OP_START, 48'hFFFFFFFFFFFF);
        send_mark(fijs_pkg::OP_END, 48'h3);
        send_mark(fijs_pkg::OP_NONE, 48'h10);
        send_mark(fijs_pkg::OP_END, 48'h20);
        send_mark(fijs_pkg::OP_CYCLE, 48'h20);
        send_mark(fijs_pkg::OP_CYCLE, 48'h20);
        send_mark(fijs_pkg::OP_START, 48'h0);
        send_mark(fijs_pkg::OP_END, 48'hFFFFFFFFFFFF);
        write_window(2);
        send_mark(fijs_pkg::OP_START, 48'h0);
        send_mark(fijs_pkg::OP_CYCLE, 48'h1);
        send_mark(fijs_pkg::OP_CYCLE, 48'h1000001);
        send_mark(fijs_pkg::OP_CYCLE, 48'h7FFFFFFFFFFF);
        send_mark(fijs_pkg::OP_CYCLE, 48'h800000000000);
        send_mark(fijs_pkg::OP_CYCLE, 48'h800000000000);
        send_mark(fijs_pkg::OP_END, 48'h800000000000);
        send_mark(fijs_pkg::OP_START, 48'hAAAAAAAAAAAA);
        send_mark(fijs_pkg::OP_END, 48'hAAAAAAAAAAAB);
        send_mark(fijs_pkg::OP_START, 48'h555555555555);
        send_mark(fijs_pkg::OP_CYCLE, 48'h555555555565);
        write_window(0);
        send_mark(fijs_pkg::OP_START, 48'h0);
        send_mark(fijs_pkg::OP_END, 48'h100);

        for (int p = 0; p < 9; p++) begin
            write_window(fijs_pkg::CFG_W'(lens[p]));
            set_idling(p);
            run_marks(cnts[p]);
        end

        // The receiver holds off while marks keep coming, so the engine stalls and the input is held off.
        write_window(1);
        set_idling(0);
        hold_left = 3000;
        run_marks(40);

        drain();
        if (sb.errors == 0 && sb.stats_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
